// File: rtl/core/sts_pkg.sv
`default_nettype none

package sts_pkg;

	// luma clamp band
	localparam logic [7:0] Y_LO = 8'd16;
	localparam logic [7:0] Y_HI = 8'd235;

	// cluster widths, Q8.8
	localparam int W_CR    = 9923;
	localparam int W_CB    = 12024;
	localparam int WL_CR   = 5120;
	localparam int WL_CB   = 5888;
	localparam int WH_CR   = 2560;
	localparam int WH_CB   = 3584;

	// chroma means, Q8.8
	localparam int M_CR    = 39424;
	localparam int M_CB    = 27648;

	// rotation centre, Q8.8
	localparam int CX      = 28001;
	localparam int CY      = 38917;

	localparam logic [15:0] HALF_Q16 = 16'd32768;

	// divider geometry
	localparam int DIV_BPS = 2;
	localparam int T_NW    = 24;
	localparam int T_DW    = 8;
	localparam int T_QW    = 17;
	localparam int W_NW    = 30;
	localparam int W_DW    = 14;
	localparam int W_QW    = 19;
	localparam int L_T     = (T_QW + DIV_BPS - 1) / DIV_BPS;
	localparam int L_W     = (W_QW + DIV_BPS - 1) / DIV_BPS;

	typedef enum logic [2:0] {
		REG_K_LOW,
		REG_K_HIGH,
		REG_COS,
		REG_SIN,
		REG_OFF_X,
		REG_OFF_Y,
		REG_INV_A,
		REG_INV_B
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] cr;
		logic [7:0] cb;
		logic       inband;
		logic       lower;
		logic       khlt;
		logic       tsat;
		logic       ktsat;
	} sb1_t;

	typedef struct packed {
		logic [7:0]  cr;
		logic [7:0]  cb;
		logic        inband;
		logic        neg_cr;
		logic        neg_cb;
		logic [15:0] kcr;
		logic [15:0] kcb;
	} sb2_t;

endpackage

`default_nettype wire

// File: rtl/core/sts_div.sv
`default_nettype none

// pipelined restoring divider, BPS quotient bits per stage; quotient must fit QW bits
module sts_div #(
	parameter int NW  = 24,
	parameter int DW  = 8,
	parameter int QW  = 17,
	parameter int BPS = 2
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo
);

	localparam int NS = (QW + BPS - 1) / BPS;
	localparam int WW = (NW > DW + QW) ? NW : DW + QW;

	logic [NW-1:0] rem_s [NS];
	logic [DW-1:0] den_s [NS];
	logic [QW-1:0] q_s   [NS];

	for (genvar g = 0; g < NS; g++) begin : g_stage
		logic [NW-1:0] r_in, r_nx;
		logic [DW-1:0] d_in;
		logic [QW-1:0] q_in, q_nx;

		if (g == 0) begin : g_first
			assign r_in = num;
			assign d_in = den;
			assign q_in = '0;
		end else begin : g_next
			assign r_in = rem_s[g-1];
			assign d_in = den_s[g-1];
			assign q_in = q_s[g-1];
		end

		always_comb begin
			logic [WW-1:0] sh;
			int            b;
			r_nx = r_in;
			q_nx = q_in;
			sh   = '0;
			for (int j = 0; j < BPS; j++) begin
				b = QW - 1 - (g * BPS + j);
				if (b >= 0) begin
					sh = WW'(d_in) << b;
					if (WW'(r_nx) >= sh) begin
						r_nx = NW'(WW'(r_nx) - sh);
						q_nx[b] = 1'b1;
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g] <= r_nx;
				den_s[g] <= d_in;
				q_s[g]   <= q_nx;
			end
		end
	end

	assign quo = q_s[NS-1];

endmodule

`default_nettype wire

// File: rtl/core/skin_tone_score_top.sv
// Throughput: one pixel per cycle; the whole pipe advances unless the output
// register holds a word that is stalled.
// Most of the depth comes from the two pipelined divider banks, fraction and scale (2 quotient bits per stage).
// Reset clears all valid bits and loads the register defaults.
`default_nettype none

module skin_tone_score_top
	import sts_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        pixel_valid,
	output logic        pixel_stall,
	input  logic [7:0]  luma,
	input  logic [7:0]  chroma_red,
	input  logic [7:0]  chroma_blue,
	output logic        score_valid,
	input  logic        score_stall,
	output logic [7:0]  skin_score
);

	// ---------------- configuration ----------------
	logic [7:0]  k_low_q, k_high_q;
	logic [15:0] cos_q, sin_q, offx_q, offy_q;
	logic [23:0] inv_a_q, inv_b_q;
	reg_idx_t    ridx;

	assign pready = 1'b1;
	assign ridx   = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_low_q  <= 8'd125;
			k_high_q <= 8'd188;
			cos_q    <= 16'hCBA6;
			sin_q    <= 16'd9410;
			offx_q   <= 16'd410;
			offy_q   <= 16'd617;
			inv_a_q  <= 24'd26025;
			inv_b_q  <= 24'd85233;
		end else if (psel && penable && pwrite) begin
			unique case (ridx)
				REG_K_LOW:  k_low_q  <= pwdata[7:0];
				REG_K_HIGH: k_high_q <= pwdata[7:0];
				REG_COS:    cos_q    <= pwdata[15:0];
				REG_SIN:    sin_q    <= pwdata[15:0];
				REG_OFF_X:  offx_q   <= pwdata[15:0];
				REG_OFF_Y:  offy_q   <= pwdata[15:0];
				REG_INV_A:  inv_a_q  <= pwdata[23:0];
				REG_INV_B:  inv_b_q  <= pwdata[23:0];
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			REG_K_LOW:  prdata = {24'd0, k_low_q};
			REG_K_HIGH: prdata = {24'd0, k_high_q};
			REG_COS:    prdata = {16'd0, cos_q};
			REG_SIN:    prdata = {16'd0, sin_q};
			REG_OFF_X:  prdata = {16'd0, offx_q};
			REG_OFF_Y:  prdata = {16'd0, offy_q};
			REG_INV_A:  prdata = {8'd0, inv_a_q};
			REG_INV_B:  prdata = {8'd0, inv_b_q};
		endcase
	end

	// ---------------- flow control ----------------
	logic en;
	logic score_valid_q;
	logic [7:0] score_q;

	assign en          = !(score_valid_q && score_stall);
	assign pixel_stall = !en;
	assign score_valid = score_valid_q;
	assign skin_score  = score_q;

	// ---------------- s1: branch select, fraction operands ----------------
	logic [7:0]        yc, khc;
	logic signed [9:0] nm, dn, knm, kdn;
	logic [7:0]        nmc, knmc;
	logic              lower_c, inband_c;

	always_comb begin
		yc  = (luma < Y_LO) ? Y_LO : ((luma > Y_HI) ? Y_HI : luma);
		khc = (k_high_q < Y_LO) ? Y_LO : ((k_high_q > Y_HI) ? Y_HI : k_high_q);
		lower_c  = luma < k_low_q;
		inband_c = (luma >= k_low_q) && (luma <= k_high_q);
		if (lower_c) begin
			dn = $signed({2'b00, k_low_q}) - $signed({2'b00, Y_LO});
			nm = $signed({2'b00, k_low_q}) - $signed({2'b00, yc});
		end else begin
			dn = $signed({2'b00, Y_HI}) - $signed({2'b00, k_high_q});
			nm = $signed({2'b00, yc}) - $signed({2'b00, k_high_q});
		end
		kdn = $signed({2'b00, k_low_q}) - $signed({2'b00, Y_LO});
		knm = $signed({2'b00, k_low_q}) - $signed({2'b00, khc});
		nmc  = (nm < 10'sd0) ? 8'd0 : ((nm > dn) ? dn[7:0] : nm[7:0]);
		knmc = (knm < 10'sd0) ? 8'd0 : ((knm > kdn) ? kdn[7:0] : knm[7:0]);
	end

	logic             v_s1;
	sb1_t             sb_s1;
	logic [T_NW-1:0]  tnum_s1, ktnum_s1;
	logic [T_DW-1:0]  tden_s1, ktden_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= pixel_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s1.cr     <= chroma_red;
			sb_s1.cb     <= chroma_blue;
			sb_s1.inband <= inband_c;
			sb_s1.lower  <= lower_c;
			sb_s1.khlt   <= k_high_q < k_low_q;
			sb_s1.tsat   <= dn <= 10'sd0;
			sb_s1.ktsat  <= kdn <= 10'sd0;
			tnum_s1      <= {nmc, 16'd0} + T_NW'(dn[7:1]);
			tden_s1      <= dn[7:0];
			ktnum_s1     <= {knmc, 16'd0} + T_NW'(kdn[7:1]);
			ktden_s1     <= kdn[7:0];
		end
	end

	// ---------------- fraction dividers ----------------
	logic [T_QW-1:0] tq, ktq;

	sts_div #(.NW(T_NW), .DW(T_DW), .QW(T_QW), .BPS(DIV_BPS)) u_div_t (
		.clk(clk), .en(en), .num(tnum_s1), .den(tden_s1), .quo(tq)
	);

	sts_div #(.NW(T_NW), .DW(T_DW), .QW(T_QW), .BPS(DIV_BPS)) u_div_kt (
		.clk(clk), .en(en), .num(ktnum_s1), .den(ktden_s1), .quo(ktq)
	);

	logic [L_T-1:0] dl1_v;
	sb1_t           dl1 [L_T];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dl1_v <= '0;
		else if (en) dl1_v <= {dl1_v[L_T-2:0], v_s1};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dl1[0] <= sb_s1;
			for (int i = 1; i < L_T; i++) dl1[i] <= dl1[i-1];
		end
	end

	// ---------------- s2: means and width products ----------------
	sb1_t        sb_t;
	logic [16:0] t, kt, omt;
	logic [11:0] rr, rk;
	logic [12:0] ru;

	always_comb begin
		sb_t = dl1[L_T-1];
		t    = sb_t.tsat  ? 17'h10000 : tq;
		kt   = sb_t.ktsat ? 17'h10000 : ktq;
		omt  = 17'h10000 - t;
		rr   = 12'((28'(t)  * 28'd2560 + 28'd32768) >> 16);
		rk   = 12'((28'(kt) * 28'd2560 + 28'd32768) >> 16);
		ru   = 13'((29'(t)  * 29'd5632 + 29'd32768) >> 16);
	end

	logic        v_s2;
	sb1_t        sb_s2;
	logic [15:0] mcr_s2, mcb_s2, kcr_s2, kcb_s2;
	logic [30:0] pwcr_s2, pwcb_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= dl1_v[L_T-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s2   <= sb_t;
			mcr_s2  <= sb_t.lower ? 16'(M_CR - 32'(rr)) : 16'(M_CR + 32'(ru));
			mcb_s2  <= 16'(M_CB + 32'(rr));
			kcr_s2  <= sb_t.khlt ? 16'(M_CR - 32'(rk)) : 16'(M_CR);
			kcb_s2  <= sb_t.khlt ? 16'(M_CB + 32'(rk)) : 16'(M_CB);
			pwcr_s2 <= 31'(sb_t.lower ? W_CR - WL_CR : W_CR - WH_CR) * 31'(omt);
			pwcb_s2 <= 31'(sb_t.lower ? W_CB - WL_CB : W_CB - WH_CB) * 31'(omt);
		end
	end

	// ---------------- s3: widths and scaled numerators ----------------
	logic signed [17:0] difcr, difcb;

	always_comb begin
		difcr = $signed({2'b00, sb_s2.cr, 8'd0}) - $signed({2'b00, mcr_s2});
		difcb = $signed({2'b00, sb_s2.cb, 8'd0}) - $signed({2'b00, mcb_s2});
	end

	logic               v_s3;
	sb1_t               sb_s3;
	logic [15:0]        kcr_s3, kcb_s3;
	logic [W_DW-1:0]    wcr_s3, wcb_s3;
	logic signed [32:0] ncr_s3, ncb_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s3  <= sb_s2;
			kcr_s3 <= kcr_s2;
			kcb_s3 <= kcb_s2;
			wcr_s3 <= W_DW'(sb_s2.lower ? WL_CR : WH_CR) + W_DW'((pwcr_s2 + 31'd32768) >> 16);
			wcb_s3 <= W_DW'(sb_s2.lower ? WL_CB : WH_CB) + W_DW'((pwcb_s2 + 31'd32768) >> 16);
			ncr_s3 <= 33'(difcr) * 33'(W_CR);
			ncb_s3 <= 33'(difcb) * 33'(W_CB);
		end
	end

	// ---------------- s4: magnitude plus half divisor ----------------
	logic [32:0] mcr_abs, mcb_abs;

	always_comb begin
		mcr_abs = ncr_s3[32] ? 33'(-ncr_s3) : 33'(ncr_s3);
		mcb_abs = ncb_s3[32] ? 33'(-ncb_s3) : 33'(ncb_s3);
	end

	logic            v_s4;
	sb2_t            sb_s4;
	logic [W_NW-1:0] dvcr_s4, dvcb_s4;
	logic [W_DW-1:0] wcr_s4, wcb_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s4.cr     <= sb_s3.cr;
			sb_s4.cb     <= sb_s3.cb;
			sb_s4.inband <= sb_s3.inband;
			sb_s4.neg_cr <= ncr_s3[32];
			sb_s4.neg_cb <= ncb_s3[32];
			sb_s4.kcr    <= kcr_s3;
			sb_s4.kcb    <= kcb_s3;
			dvcr_s4      <= W_NW'(mcr_abs) + W_NW'(wcr_s3 >> 1);
			dvcb_s4      <= W_NW'(mcb_abs) + W_NW'(wcb_s3 >> 1);
			wcr_s4       <= wcr_s3;
			wcb_s4       <= wcb_s3;
		end
	end

	// ---------------- scale dividers ----------------
	logic [W_QW-1:0] qcr, qcb;

	sts_div #(.NW(W_NW), .DW(W_DW), .QW(W_QW), .BPS(DIV_BPS)) u_div_cr (
		.clk(clk), .en(en), .num(dvcr_s4), .den(wcr_s4), .quo(qcr)
	);

	sts_div #(.NW(W_NW), .DW(W_DW), .QW(W_QW), .BPS(DIV_BPS)) u_div_cb (
		.clk(clk), .en(en), .num(dvcb_s4), .den(wcb_s4), .quo(qcb)
	);

	logic [L_W-1:0] dl2_v;
	sb2_t           dl2 [L_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dl2_v <= '0;
		else if (en) dl2_v <= {dl2_v[L_W-2:0], v_s4};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dl2[0] <= sb_s4;
			for (int i = 1; i < L_W; i++) dl2[i] <= dl2[i-1];
		end
	end

	// ---------------- s5: transformed chroma, centre offset ----------------
	sb2_t               sb_w;
	logic signed [20:0] vcr, vcb;
	logic [15:0]        tcr, tcb;

	always_comb begin
		sb_w = dl2[L_W-1];
		vcr = sb_w.neg_cr ? $signed({5'd0, sb_w.kcr}) - $signed({2'd0, qcr})
		                  : $signed({5'd0, sb_w.kcr}) + $signed({2'd0, qcr});
		vcb = sb_w.neg_cb ? $signed({5'd0, sb_w.kcb}) - $signed({2'd0, qcb})
		                  : $signed({5'd0, sb_w.kcb}) + $signed({2'd0, qcb});
		if (sb_w.inband) begin
			tcr = {sb_w.cr, 8'd0};
			tcb = {sb_w.cb, 8'd0};
		end else begin
			tcr = (vcr < 21'sd0) ? 16'd0 : ((vcr > 21'sd65535) ? 16'hFFFF : vcr[15:0]);
			tcb = (vcb < 21'sd0) ? 16'd0 : ((vcb > 21'sd65535) ? 16'hFFFF : vcb[15:0]);
		end
	end

	logic               v_s5;
	logic signed [16:0] dx_s5, dy_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= dl2_v[L_W-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s5 <= $signed({1'b0, tcb}) - 17'(CX);
			dy_s5 <= $signed({1'b0, tcr}) - 17'(CY);
		end
	end

	// ---------------- s6: rotation products ----------------
	logic               v_s6;
	logic signed [32:0] pcx_s6, psy_s6, pcy_s6, psx_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (en) v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pcx_s6 <= 33'($signed(cos_q)) * 33'(dx_s5);
			psy_s6 <= 33'($signed(sin_q)) * 33'(dy_s5);
			pcy_s6 <= 33'($signed(cos_q)) * 33'(dy_s5);
			psx_s6 <= 33'($signed(sin_q)) * 33'(dx_s5);
		end
	end

	// ---------------- s7: rotated sums, rounded magnitude ----------------
	logic signed [33:0] sx, sy;
	logic [33:0]        ax, ay;

	always_comb begin
		sx = 34'(pcx_s6) + 34'(psy_s6);
		sy = 34'(pcy_s6) - 34'(psx_s6);
		ax = sx[33] ? 34'(-sx) : 34'(sx);
		ay = sy[33] ? 34'(-sy) : 34'(sy);
	end

	logic        v_s7, nx_s7, ny_s7;
	logic [19:0] rx_s7, ry_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else if (en) v_s7 <= v_s6;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s7 <= sx[33];
			ny_s7 <= sy[33];
			rx_s7 <= 20'((ax + 34'd8192) >> 14);
			ry_s7 <= 20'((ay + 34'd8192) >> 14);
		end
	end

	// ---------------- s8: ellipse offsets ----------------
	logic signed [21:0] ex, ey;

	always_comb begin
		ex = (nx_s7 ? -$signed({2'b0, rx_s7}) : $signed({2'b0, rx_s7})) - 22'($signed(offx_q));
		ey = (ny_s7 ? -$signed({2'b0, ry_s7}) : $signed({2'b0, ry_s7})) - 22'($signed(offy_q));
	end

	logic        v_s8;
	logic [17:0] ex_s8, ey_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8 <= 1'b0;
		else if (en) v_s8 <= v_s7;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ex_s8 <= 18'(ex[21] ? -ex : ex);
			ey_s8 <= 18'(ey[21] ? -ey : ey);
		end
	end

	// ---------------- s9: squares ----------------
	logic        v_s9;
	logic [35:0] ex2_s9, ey2_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s9 <= 1'b0;
		else if (en) v_s9 <= v_s8;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ex2_s9 <= 36'(ex_s8) * 36'(ex_s8);
			ey2_s9 <= 36'(ey_s8) * 36'(ey_s8);
		end
	end

	// ---------------- s10: axis weights, split products ----------------
	logic        v_s10;
	logic [41:0] pah_s10, pal_s10, pbh_s10, pbl_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s10 <= 1'b0;
		else if (en) v_s10 <= v_s9;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pah_s10 <= 42'(ex2_s9[35:18]) * 42'(inv_a_q);
			pal_s10 <= 42'(ex2_s9[17:0])  * 42'(inv_a_q);
			pbh_s10 <= 42'(ey2_s9[35:18]) * 42'(inv_b_q);
			pbl_s10 <= 42'(ey2_s9[17:0])  * 42'(inv_b_q);
		end
	end

	// ---------------- s11: distance, Q0.16 ----------------
	logic [61:0] dsum;
	logic [37:0] dq;

	always_comb begin
		dsum = (62'(pah_s10) << 18) + 62'(pal_s10) + (62'(pbh_s10) << 18)
		     + 62'(pbl_s10) + 62'(1 << 23);
		dq   = 38'(dsum >> 24);
	end

	logic        v_s11;
	logic [15:0] d_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s11 <= 1'b0;
		else if (en) v_s11 <= v_s10;
	end

	always_ff @(posedge clk) begin
		if (en) d_s11 <= (dq >= 38'(HALF_Q16)) ? HALF_Q16 : dq[15:0];
	end

	// ---------------- output register ----------------
	logic [25:0] sc;

	always_comb begin
		sc = (26'd510 * 26'(HALF_Q16 - d_s11)) >> 16;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) score_valid_q <= 1'b0;
		else if (en) score_valid_q <= v_s11;
	end

	always_ff @(posedge clk) begin
		if (en) score_q <= (sc > 26'd255) ? 8'hFF : sc[7:0];
	end

endmodule

`default_nettype wire

// File: rtl/core/sts_chk.sv
`default_nettype none

module sts_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       pready,
	input logic       pixel_stall,
	input logic       score_valid,
	input logic       score_stall,
	input logic [7:0] skin_score
);

	// a stalled score word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		score_valid && score_stall |=> score_valid && $stable(skin_score))
		else $error("score word changed under stall");

	// input backpressure only from a blocked output word
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_stall |-> score_valid && score_stall)
		else $error("pixel stall without blocked output");

	a_stall_set: assert property (@(posedge clk) disable iff (!arst_n)
		score_valid && score_stall |-> pixel_stall)
		else $error("pipe advanced over blocked output");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

endmodule

bind skin_tone_score_top sts_chk u_sts_chk (
	.clk(clk),
	.arst_n(arst_n),
	.pready(pready),
	.pixel_stall(pixel_stall),
	.score_valid(score_valid),
	.score_stall(score_stall),
	.skin_score(skin_score)
);

`default_nettype wire
